/* design/lqm_pkg.sv */
`timescale 1ns / 1ps

package lqm_pkg;

  localparam int POOL_SIZE   = 64;
  localparam int QUEUE_COUNT = 4;

  localparam int EW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int LW = $clog2(POOL_SIZE + 1);

  localparam int CMD_W  = 2;
  localparam int QID_W  = 2;
  localparam int ELEM_W = 6;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;
  localparam int HEAD_W = 6;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [EW-1:0]     elem_t;
  typedef logic [QW-1:0]     qsel_t;
  typedef logic [LW-1:0]     cnt_t;

  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  localparam stat_t ST_OK     = 2'd0;
  localparam stat_t ST_QUEUED = 2'd1;
  localparam stat_t ST_MISS   = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic link2;
    logic out_load;
  } lqm_ctl_t;

  typedef struct packed {
    logic need_link2;
  } lqm_sts_t;

endpackage

/* design/lqm_req_if.sv */
`timescale 1ns / 1ps

interface lqm_req_if import lqm_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [QID_W-1:0]  queue_id;
  logic [ELEM_W-1:0] element_index;

  modport source (output valid, output command, output queue_id, output element_index,
                  input ready);
  modport sink (input valid, input command, input queue_id, input element_index,
                output ready);
endinterface

/* design/lqm_rsp_if.sv */
`timescale 1ns / 1ps

interface lqm_rsp_if import lqm_pkg::*; ();
  logic              valid;
  logic              ready;
  stat_t             status;
  logic [LEN_W-1:0]  length;
  logic [HEAD_W-1:0] head_index;
  logic              queue_empty;

  modport source (output valid, output status, output length, output head_index,
                  output queue_empty, input ready);
  modport sink (input valid, input status, input length, input head_index,
                input queue_empty, output ready);
endinterface

/* design/lqm_ram.sv */
`timescale 1ns / 1ps

module lqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/lqm_ctrl.sv */
`timescale 1ns / 1ps

module lqm_ctrl import lqm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lqm_sts_t sts,
  output lqm_ctl_t ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_LINK2 = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.need_link2) begin
          state_next = S_LINK2;
        end else if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_LINK2: begin
        ctl.link2 = 1'b1;
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("Result register loaded while an item is still waiting.");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("Accepted item did not enter execution.");

  a_link2_order: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK2 |-> $past(state) == S_EXEC)
    else $error("Second link write not preceded by execution.");

endmodule

/* design/lqm_dp.sv */
`timescale 1ns / 1ps

module lqm_dp import lqm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lqm_ctl_t          ctl,
  output lqm_sts_t          sts,
  input  cmd_t              in_command,
  input  logic [QID_W-1:0]  in_queue_id,
  input  logic [ELEM_W-1:0] in_element_index,
  output stat_t             out_status,
  output logic [LEN_W-1:0]  out_length,
  output logic [HEAD_W-1:0] out_head_index,
  output logic              out_queue_empty
);

  elem_t                head [QUEUE_COUNT];
  cnt_t                 count [QUEUE_COUNT];
  logic [POOL_SIZE-1:0] queued;

  cmd_t  cmd_r;
  qsel_t q_r;
  elem_t e_r;
  logic  qok_r;
  logic  eok_r;
  elem_t t_r;
  elem_t h_r;
  stat_t status_r;

  logic  qok_in;
  logic  eok_in;
  qsel_t q_in;
  elem_t e_in;
  elem_t rd_addr;

  elem_t nx;
  elem_t pv;
  qsel_t owner_rd;

  cnt_t  cnt;
  elem_t hd;
  logic  qd;
  logic  is_app;
  logic  is_rem;
  stat_t st;
  logic  do_app;
  logic  do_rem;
  logic  app;
  logic  rem;
  cnt_t  cnt_new;
  elem_t head_new;

  logic  next_we;
  elem_t next_wa;
  elem_t next_wd;
  logic  prev_we;
  elem_t prev_wa;
  elem_t prev_wd;

  stat_t view_status;
  cnt_t  view_len;
  elem_t view_head;

  assign qok_in  = 32'(in_queue_id) < QUEUE_COUNT;
  assign eok_in  = 32'(in_element_index) < POOL_SIZE;
  assign q_in    = qsel_t'(in_queue_id);
  assign e_in    = elem_t'(in_element_index);
  assign rd_addr = (in_command == CMD_APPEND) ? head[q_in] : e_in;

  lqm_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_wa),
    .wdata (next_wd),
    .re    (ctl.load),
    .raddr (rd_addr),
    .rdata (nx)
  );

  lqm_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .re    (ctl.load),
    .raddr (rd_addr),
    .rdata (pv)
  );

  lqm_ram #(.WIDTH(QW), .DEPTH(POOL_SIZE)) u_owner_ram (
    .clk   (clk),
    .we    (app),
    .waddr (e_r),
    .wdata (q_r),
    .re    (ctl.load),
    .raddr (e_in),
    .rdata (owner_rd)
  );

  assign cnt    = count[q_r];
  assign hd     = head[q_r];
  assign qd     = queued[e_r];
  assign is_app = (cmd_r == CMD_APPEND);
  assign is_rem = (cmd_r == CMD_REMOVE);

  always_comb begin
    st     = ST_OK;
    do_app = 1'b0;
    do_rem = 1'b0;
    if (!qok_r) begin
      st = ST_MISS;
    end else if ((is_app || is_rem) && !eok_r) begin
      st = ST_MISS;
    end else if (is_app) begin
      if (qd) begin
        st = ST_QUEUED;
      end else begin
        do_app = 1'b1;
      end
    end else if (is_rem) begin
      if (cnt == '0 || !qd || owner_rd != q_r) begin
        st = ST_MISS;
      end else begin
        do_rem = 1'b1;
      end
    end
  end

  assign app            = ctl.exec && do_app;
  assign rem            = ctl.exec && do_rem;
  assign sts.need_link2 = do_app && (cnt != '0);

  always_comb begin
    cnt_new  = cnt;
    head_new = hd;
    if (app) begin
      cnt_new = cnt + cnt_t'(1);
      if (cnt == '0) begin
        head_new = e_r;
      end
    end else if (rem) begin
      cnt_new = cnt - cnt_t'(1);
      if (cnt == cnt_t'(1)) begin
        head_new = '0;
      end else if (hd == e_r) begin
        head_new = nx;
      end
    end
  end

  always_comb begin
    next_we = 1'b0;
    next_wa = e_r;
    next_wd = e_r;
    prev_we = 1'b0;
    prev_wa = e_r;
    prev_wd = e_r;
    if (ctl.link2) begin
      next_we = 1'b1;
      next_wa = t_r;
      prev_we = 1'b1;
      prev_wa = h_r;
    end else if (app) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      if (cnt != '0) begin
        next_wd = hd;
        prev_wd = pv;
      end
    end else if (rem && cnt != cnt_t'(1)) begin
      next_we = 1'b1;
      next_wa = pv;
      next_wd = nx;
      prev_we = 1'b1;
      prev_wa = nx;
      prev_wd = pv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      queued <= '0;
    end else if (app || rem) begin
      count[q_r]  <= cnt_new;
      head[q_r]   <= head_new;
      queued[e_r] <= app;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      q_r   <= q_in;
      e_r   <= e_in;
      qok_r <= qok_in;
      eok_r <= eok_in;
    end
    if (ctl.exec) begin
      status_r <= st;
      t_r      <= pv;
      h_r      <= hd;
    end
  end

  assign view_status = ctl.exec ? st : status_r;
  assign view_len    = qok_r ? cnt_new : '0;
  assign view_head   = (qok_r && cnt_new != '0) ? head_new : '0;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status      <= view_status;
      out_length      <= LEN_W'(view_len);
      out_head_index  <= HEAD_W'(view_head);
      out_queue_empty <= (view_len == '0);
    end
  end

  a_head_queued: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && qok_r && cnt != '0 |-> queued[hd])
    else $error("Head of a nonempty queue is not marked as queued.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && do_app |-> 32'(cnt) < POOL_SIZE)
    else $error("Append into a queue that already holds the whole pool.");

endmodule

/* design/linked_queue_manager_unit.sv */
`timescale 1ns / 1ps

// Keeps several circular doubly linked queues over one shared pool of elements and
// answers each command item (append at tail, remove anywhere, query length) with one
// result item giving status, length, head and an empty flag. An item is taken only
// while the controller is idle. A query, a remove, a refused append or an append to
// an empty queue passes through the execute state before the next item is taken. An
// append that joins a nonempty queue also enters the second link-write state,
// because it needs two writes into each link memory, which has a single write port.
// A result that is not taken holds the controller until the result register frees
// up. All queues are empty after reset, with no clearing pass.
module linked_queue_manager_unit import lqm_pkg::*; (
  input logic      clk,
  input logic      rst,
  lqm_req_if.sink  request,
  lqm_rsp_if.source response
);

  lqm_ctl_t ctl;
  lqm_sts_t sts;

  lqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lqm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (request.command),
    .in_queue_id      (request.queue_id),
    .in_element_index (request.element_index),
    .out_status       (response.status),
    .out_length       (response.length),
    .out_head_index   (response.head_index),
    .out_queue_empty  (response.queue_empty)
  );

endmodule

/* tb/sv/lqm_queue_checker.sv */
`timescale 1ns / 1ps

module lqm_queue_checker import lqm_pkg::*; (
  input  logic clk,
  input  logic rst,
  lqm_req_if   request,
  lqm_rsp_if   response,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    stat_t             status;
    logic [LEN_W-1:0]  length;
    logic [HEAD_W-1:0] head_index;
    logic              queue_empty;
  } reply_t;

  reply_t expected_replies[$];

  elem_t ring_head  [QUEUE_COUNT];
  cnt_t  ring_count [QUEUE_COUNT];
  elem_t succ       [POOL_SIZE];
  elem_t pred       [POOL_SIZE];
  logic  in_ring    [POOL_SIZE];
  qsel_t ring_of    [POOL_SIZE];

  int issued;
  int answered;

  assign outstanding = issued - answered;

  function reply_t predict_reply(cmd_t op, qsel_t q, elem_t e);
    elem_t  h;
    elem_t  t;
    elem_t  n;
    elem_t  p;
    stat_t  st;
    reply_t r;
    st = ST_OK;
    if (op == CMD_APPEND) begin
      if (in_ring[e]) begin
        st = ST_QUEUED;
      end else begin
        if (ring_count[q] == 0) begin
          ring_head[q] = e;
          succ[e] = e;
          pred[e] = e;
        end else begin
          h = ring_head[q];
          t = pred[h];
          pred[e] = t;
          succ[e] = h;
          succ[t] = e;
          pred[h] = e;
        end
        in_ring[e] = 1'b1;
        ring_of[e] = q;
        ring_count[q] = ring_count[q] + 1'b1;
      end
    end else if (op == CMD_REMOVE) begin
      if (ring_count[q] == 0 || !in_ring[e] || ring_of[e] != q) begin
        st = ST_MISS;
      end else begin
        if (ring_count[q] == 1) begin
          ring_head[q] = '0;
        end else begin
          n = succ[e];
          p = pred[e];
          if (ring_head[q] == e) ring_head[q] = n;
          succ[p] = n;
          pred[n] = p;
        end
        in_ring[e] = 1'b0;
        ring_count[q] = ring_count[q] - 1'b1;
      end
    end
    r.status      = st;
    r.length      = ring_count[q];
    r.head_index  = (ring_count[q] != 0) ? ring_head[q] : '0;
    r.queue_empty = (ring_count[q] == 0);
    return r;
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      expected_replies.delete();
      issued <= 0;
      answered <= 0;
      mismatch_count = 0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        ring_head[i] = '0;
        ring_count[i] = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
        in_ring[i] = 1'b0;
        ring_of[i] = '0;
        succ[i] = '0;
        pred[i] = '0;
      end
    end else begin
      if (response.valid && response.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (status %0d length %0d)",
                                    response.status, response.length));
        end else begin
          want = expected_replies.pop_front();
          answered <= answered + 1;
          if (response.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      response.status, want.status));
          if (response.length !== want.length)
            report_mismatch($sformatf("length got %0d expected %0d",
                                      response.length, want.length));
          if (response.head_index !== want.head_index)
            report_mismatch($sformatf("head_index got %0d expected %0d",
                                      response.head_index, want.head_index));
          if (response.queue_empty !== want.queue_empty)
            report_mismatch($sformatf("queue_empty got %0d expected %0d",
                                      response.queue_empty, want.queue_empty));
        end
      end
      if (request.valid && request.ready) begin
        expected_replies.push_back(predict_reply(request.command, request.queue_id,
                                                 request.element_index));
        issued <= issued + 1;
      end
    end
  end

endmodule

/* tb/sv/tb_linked_queue_manager_unit.sv */
`timescale 1ns / 1ps

module tb_linked_queue_manager_unit;
  import lqm_pkg::*;

  localparam cmd_t CMD_UNUSED  = 2'd3;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   RANDOM_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst;

  lqm_req_if request ();
  lqm_rsp_if response ();

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  bit steady_flow = 1'b0;
  int home_queue [POOL_SIZE];
  int queued_total = 0;

  linked_queue_manager_unit dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  lqm_queue_checker reply_check (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .response       (response),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function int find_slot(bit want_free);
    int start;
    int idx;
    start = $urandom_range(0, POOL_SIZE - 1);
    for (int k = 0; k < POOL_SIZE; k++) begin
      idx = (start + k) % POOL_SIZE;
      if ((home_queue[idx] < 0) == want_free) return idx;
    end
    return start;
  endfunction

  task send_item(cmd_t op, qsel_t q, elem_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid         <= 1'b1;
    request.command       <= op;
    request.queue_id      <= q;
    request.element_index <= e;
    do @(posedge clk); while (request.ready !== 1'b1);
    if (op == CMD_APPEND && home_queue[e] < 0) begin
      home_queue[e] = q;
      queued_total++;
    end else if (op == CMD_REMOVE && home_queue[e] == int'(q)) begin
      home_queue[e] = -1;
      queued_total--;
    end
  endtask

  task drain();
    request.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : response_side
    int run;
    int stall;
    response.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      run = $urandom_range(1, 16);
      response.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        response.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   r;
    int   fill_target;
    int   favored_q;
    cmd_t op;
    int   q;
    int   e;
    bit   grow;
    rst                   <= 1'b1;
    request.valid         <= 1'b0;
    request.command       <= CMD_QUERY;
    request.queue_id      <= '0;
    request.element_index <= '0;
    fill_target = 8;
    favored_q = 0;
    for (int i = 0; i < POOL_SIZE; i++) home_queue[i] = -1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_QUERY,  2'd0, 6'd0);
    send_item(CMD_REMOVE, 2'd1, 6'd5);
    send_item(CMD_APPEND, 2'd0, 6'd0);
    send_item(CMD_APPEND, 2'd0, 6'd63);
    send_item(CMD_APPEND, 2'd0, 6'd42);
    send_item(CMD_APPEND, 2'd0, 6'd0);
    send_item(CMD_APPEND, 2'd2, 6'd63);
    send_item(CMD_REMOVE, 2'd1, 6'd0);
    send_item(CMD_REMOVE, 2'd0, 6'd7);
    send_item(CMD_REMOVE, 2'd0, 6'd63);
    send_item(CMD_REMOVE, 2'd0, 6'd0);
    send_item(CMD_REMOVE, 2'd0, 6'd42);
    send_item(CMD_APPEND, 2'd3, 6'd21);
    send_item(CMD_APPEND, 2'd3, 6'd63);
    send_item(CMD_APPEND, 2'd3, 6'd0);
    send_item(CMD_UNUSED, 2'd3, 6'd63);
    send_item(CMD_QUERY,  2'd3, 6'd0);
    send_item(CMD_REMOVE, 2'd3, 6'd0);
    send_item(CMD_APPEND, 2'd1, 6'd0);
    send_item(CMD_APPEND, 2'd2, 6'd42);
    send_item(CMD_REMOVE, 2'd3, 6'd21);
    send_item(CMD_APPEND, 2'd3, 6'd21);
    send_item(CMD_QUERY,  2'd1, 6'd63);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        steady_flow = ($urandom_range(0, 3) == 0);
        fill_target = $urandom_range(2, POOL_SIZE - 2);
        favored_q = $urandom_range(0, QUEUE_COUNT - 1);
      end
      if (n == RANDOM_ITEMS / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 12) begin
        op = cmd_t'($urandom_range(0, 3));
        q = $urandom_range(0, QUEUE_COUNT - 1);
        e = $urandom_range(0, POOL_SIZE - 1);
      end else if (r < 22) begin
        op = ($urandom_range(0, 4) == 0) ? CMD_UNUSED : CMD_QUERY;
        q = $urandom_range(0, QUEUE_COUNT - 1);
        e = $urandom_range(0, POOL_SIZE - 1);
      end else begin
        if (queued_total == 0) grow = 1'b1;
        else if (queued_total == POOL_SIZE) grow = 1'b0;
        else if (queued_total < fill_target) grow = ($urandom_range(0, 3) != 0);
        else grow = ($urandom_range(0, 3) == 0);
        if (grow) begin
          op = CMD_APPEND;
          e = find_slot(1'b1);
          q = $urandom_range(0, 1) ? favored_q : $urandom_range(0, QUEUE_COUNT - 1);
        end else begin
          op = CMD_REMOVE;
          e = find_slot(1'b0);
          q = home_queue[e];
        end
      end
      send_item(op, qsel_t'(q), elem_t'(e));
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/lqm_pkg.sv
design/lqm_req_if.sv
design/lqm_rsp_if.sv
design/lqm_ram.sv
design/lqm_ctrl.sv
design/lqm_dp.sv
design/linked_queue_manager_unit.sv
tb/sv/lqm_queue_checker.sv
tb/sv/tb_linked_queue_manager_unit.sv
